@@ hdl/crhp_pkg.sv @@
// Shared types, constants and helpers for the Content-Range header parser.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package crhp_pkg;

  // Width of each offset accumulator, and of the offset fields in a result.
  localparam int COUNT_WIDTH = 48;
  localparam int FIELD_WIDTH = 48;

  // Length of the "bytes " prefix; a position of this value means matched.
  localparam int PREFIX_LEN = 6;
  localparam int POS_WIDTH  = 3;

  // Characters that the parser recognises.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Which offset field the digits currently go into.
  typedef enum logic [1:0] {
    FIELD_START = 2'd0,
    FIELD_END   = 2'd1,
    FIELD_TOTAL = 2'd2
  } field_t;

  // Expected lower-case prefix character at a given match position.
  function automatic logic [7:0] prefix_char(input logic [POS_WIDTH-1:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h62; // b
      3'd1:    ch = 8'h79; // y
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h73; // s
      3'd5:    ch = 8'h20; // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage : crhp_pkg

`default_nettype wire

@@ hdl/crhp_if.sv @@
// Valid/ready channel interfaces for the Content-Range header parser.
// Uses crhp_pkg for the field widths.
`default_nettype none

// Channel that carries header value bytes into the parser.
interface crhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       is_last;

  modport source (output valid, output value_byte, output is_last, input ready);
  modport sink   (input valid, input value_byte, input is_last, output ready);
endinterface : crhp_byte_if

// Channel that carries one parse result per header value.
interface crhp_result_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic [crhp_pkg::FIELD_WIDTH-1:0] start_offset;
  logic [crhp_pkg::FIELD_WIDTH-1:0] end_offset;
  logic [crhp_pkg::FIELD_WIDTH-1:0] range_total;
  logic                            total_wildcard;

  modport source (output valid, output status, output start_offset, output end_offset,
                  output range_total, output total_wildcard, input ready);
  modport sink   (input valid, input status, input start_offset, input end_offset,
                  input range_total, input total_wildcard, output ready);
endinterface : crhp_result_if

`default_nettype wire

@@ hdl/content_range_header_parser_unit.sv @@
// Top level of the Content-Range header parser: byte-serial parse and check.
// Depends on crhp_pkg and on the channel interfaces in crhp_if.sv.
`default_nettype none

// The parser takes one byte of a Content-Range header value in every cycle,
// with a mark on the last byte, and gives one result for each value through
// the check stage and the result register. Each byte passes through a single
// multiply-by-ten accumulate and a few character compares into the parse
// state; the last byte also copies the finished fields into a check stage,
// which compares start, end and total and fills the result register. The
// state returns to its reset value with the last byte, so the first byte of
// the next value may follow in the very next cycle. The byte channel stalls
// only when a finished value waits in the check stage behind a full result
// register. Status 1 marks a bad request, in which case all offset fields and
// the unknown-total flag read as zero; a '*' total reads back as zero with
// total_wildcard set, and bytes after the '*' are ignored.
module content_range_header_parser_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  crhp_byte_if.sink          byte_chan,
  crhp_result_if.source      result_chan
);

  localparam int CW = crhp_pkg::COUNT_WIDTH;
  localparam int FW = crhp_pkg::FIELD_WIDTH;

  // Parse state.
  logic [crhp_pkg::POS_WIDTH-1:0] prefix_position, prefix_position_next;
  crhp_pkg::field_t               field_select, field_select_next;
  logic                           star_seen, star_seen_next;
  logic                           error_seen, error_seen_next;
  logic [CW-1:0]                  start_accum, start_accum_next;
  logic [CW-1:0]                  end_accum, end_accum_next;
  logic [CW-1:0]                  total_accum, total_accum_next;

  // Check stage, loaded on the last byte of a value.
  logic          snap_valid;
  logic          snap_bad;
  logic          snap_star;
  logic [CW-1:0] snap_start;
  logic [CW-1:0] snap_end;
  logic [CW-1:0] snap_total;

  // Result register.
  logic          out_valid;
  logic          out_status;
  logic [FW-1:0] out_start;
  logic [FW-1:0] out_end;
  logic [FW-1:0] out_total;
  logic          out_unknown;

  // Per-byte decode.
  logic [7:0]    lower_byte;
  logic          is_digit;
  logic [3:0]    digit;
  logic [CW-1:0] accum_sel;
  logic [CW+3:0] scaled;
  logic          overflow;
  logic          parse_bad;

  // Check stage decisions.
  logic          check_bad;

  // Handshake.
  logic          in_fire;
  logic          out_free;
  logic          snap_move;

  assign out_free        = !out_valid || result_chan.ready;
  assign snap_move       = snap_valid && out_free;
  assign byte_chan.ready = !snap_valid || snap_move;
  assign in_fire         = byte_chan.valid && byte_chan.ready;

  // Character decode and the multiply-by-ten accumulate with overflow test.
  always_comb begin
    if (byte_chan.value_byte inside {[crhp_pkg::CHAR_UPPER_A:crhp_pkg::CHAR_UPPER_Z]}) begin
      lower_byte = byte_chan.value_byte + crhp_pkg::CASE_OFFSET;
    end else begin
      lower_byte = byte_chan.value_byte;
    end
    is_digit = byte_chan.value_byte inside {[crhp_pkg::CHAR_ZERO:crhp_pkg::CHAR_NINE]};
    digit    = 4'(byte_chan.value_byte - crhp_pkg::CHAR_ZERO);
    case (field_select)
      crhp_pkg::FIELD_START: accum_sel = start_accum;
      crhp_pkg::FIELD_END:   accum_sel = end_accum;
      default:               accum_sel = total_accum;
    endcase
    scaled   = ({4'b0, accum_sel} << 3) + ({4'b0, accum_sel} << 1) + (CW + 4)'(digit);
    overflow = |scaled[CW+3:CW];
  end

  // Next parse state for the byte on the channel.
  always_comb begin
    prefix_position_next = prefix_position;
    field_select_next    = field_select;
    star_seen_next       = star_seen;
    error_seen_next      = error_seen;
    start_accum_next     = start_accum;
    end_accum_next       = end_accum;
    total_accum_next     = total_accum;
    if (!error_seen && !star_seen) begin
      if (prefix_position < crhp_pkg::POS_WIDTH'(crhp_pkg::PREFIX_LEN)) begin
        // Prefix letters match in either case; the space must be exact.
        if (lower_byte == crhp_pkg::prefix_char(prefix_position)) begin
          prefix_position_next = prefix_position + 1'b1;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (is_digit) begin
        if (overflow) begin
          error_seen_next = 1'b1;
        end else begin
          case (field_select)
            crhp_pkg::FIELD_START: start_accum_next = scaled[CW-1:0];
            crhp_pkg::FIELD_END:   end_accum_next   = scaled[CW-1:0];
            default:               total_accum_next = scaled[CW-1:0];
          endcase
        end
      end else begin
        // Separators must come in order; anything else is a stray character.
        case (byte_chan.value_byte)
          crhp_pkg::CHAR_DASH: begin
            if (field_select != crhp_pkg::FIELD_START) error_seen_next = 1'b1;
            else field_select_next = crhp_pkg::FIELD_END;
          end
          crhp_pkg::CHAR_SLASH: begin
            if (field_select != crhp_pkg::FIELD_END) error_seen_next = 1'b1;
            else field_select_next = crhp_pkg::FIELD_TOTAL;
          end
          crhp_pkg::CHAR_STAR: begin
            if (field_select != crhp_pkg::FIELD_TOTAL) error_seen_next = 1'b1;
            else star_seen_next = 1'b1;
          end
          default: error_seen_next = 1'b1;
        endcase
      end
    end
    parse_bad = error_seen_next
             || (prefix_position_next < crhp_pkg::POS_WIDTH'(crhp_pkg::PREFIX_LEN))
             || (field_select_next != crhp_pkg::FIELD_TOTAL);
  end

  // Range checks on a finished value.
  always_comb begin
    check_bad = snap_bad;
    if (snap_star && (snap_total != '0)) check_bad = 1'b1;
    if (!snap_star && (snap_total == '0)) check_bad = 1'b1;
    if (snap_start > snap_end) check_bad = 1'b1;
    if (!snap_star && ((snap_start >= snap_total) || (snap_end >= snap_total))) begin
      check_bad = 1'b1;
    end
  end

  // Control state: parse state and the stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_position <= '0;
      field_select    <= crhp_pkg::FIELD_START;
      star_seen       <= 1'b0;
      error_seen      <= 1'b0;
      start_accum     <= '0;
      end_accum       <= '0;
      total_accum     <= '0;
      snap_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        if (byte_chan.is_last) begin
          prefix_position <= '0;
          field_select    <= crhp_pkg::FIELD_START;
          star_seen       <= 1'b0;
          error_seen      <= 1'b0;
          start_accum     <= '0;
          end_accum       <= '0;
          total_accum     <= '0;
        end else begin
          prefix_position <= prefix_position_next;
          field_select    <= field_select_next;
          star_seen       <= star_seen_next;
          error_seen      <= error_seen_next;
          start_accum     <= start_accum_next;
          end_accum       <= end_accum_next;
          total_accum     <= total_accum_next;
        end
      end
      if (in_fire && byte_chan.is_last) begin
        snap_valid <= 1'b1;
      end else if (snap_move) begin
        snap_valid <= 1'b0;
      end
      if (snap_move) begin
        out_valid <= 1'b1;
      end else if (result_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload of the check stage and of the result register.
  always_ff @(posedge clk) begin
    if (in_fire && byte_chan.is_last) begin
      snap_bad   <= parse_bad;
      snap_star  <= star_seen_next;
      snap_start <= start_accum_next;
      snap_end   <= end_accum_next;
      snap_total <= total_accum_next;
    end
    if (snap_move) begin
      out_status  <= check_bad;
      out_start   <= check_bad ? '0 : FW'(snap_start);
      out_end     <= check_bad ? '0 : FW'(snap_end);
      out_total   <= (check_bad || snap_star) ? '0 : FW'(snap_total);
      out_unknown <= !check_bad && snap_star;
    end
  end

  assign result_chan.valid          = out_valid;
  assign result_chan.status         = out_status;
  assign result_chan.start_offset   = out_start;
  assign result_chan.end_offset     = out_end;
  assign result_chan.range_total    = out_total;
  assign result_chan.total_wildcard = out_unknown;

`ifndef ASSERT_OFF
  // A bad request carries no offsets and no unknown-total flag.
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status) |-> (out_start == '0 && out_end == '0 && out_total == '0
                                   && !out_unknown))
    else $error("bad result carries nonzero fields");

  // A good range never runs backwards.
  a_good_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_status) |-> (out_start <= out_end))
    else $error("good result with start after end");

  // An unknown total reads back as zero.
  a_unknown_total: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_unknown) |-> (out_total == '0 && !out_status))
    else $error("unknown total with nonzero total or bad status");

  // The last byte of a value loads the check stage and clears the parse state.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && byte_chan.is_last) |=> (snap_valid && prefix_position == '0
      && field_select == crhp_pkg::FIELD_START && !star_seen && !error_seen
      && start_accum == '0 && end_accum == '0 && total_accum == '0))
    else $error("parse state not reset after last byte");
`endif

endmodule : content_range_header_parser_unit

`default_nettype wire

@@ test/content_range_header_parser_unit_test.sv @@
// Self-checking testbench for the Content-Range header parser top level.
// Depends on crhp_pkg, the channel interfaces in crhp_if.sv and the parser RTL.
`default_nettype none

module content_range_header_parser_unit_test;

  // The prefix as one word, first character in the top byte.
  localparam logic [8*crhp_pkg::PREFIX_LEN-1:0] PREFIX_WORD = "bytes ";
  localparam logic [63:0] ACC_MASK = (64'd1 << crhp_pkg::COUNT_WIDTH) - 64'd1;
  localparam int ITEM_TARGET   = 750;

  typedef struct packed {
    logic                             status;
    logic [crhp_pkg::FIELD_WIDTH-1:0] start_offset;
    logic [crhp_pkg::FIELD_WIDTH-1:0] end_offset;
    logic [crhp_pkg::FIELD_WIDTH-1:0] range_total;
    logic                             total_wildcard;
  } range_result_t;

  // Parses header values byte by byte and holds the ranges still to come out.
  class header_value_scoreboard;
    logic [crhp_pkg::POS_WIDTH-1:0]   prefix_pos;
    crhp_pkg::field_t                 field_sel;
    bit                               star_seen;
    bit                               error_seen;
    logic [crhp_pkg::COUNT_WIDTH-1:0] start_acc;
    logic [crhp_pkg::COUNT_WIDTH-1:0] end_acc;
    logic [crhp_pkg::COUNT_WIDTH-1:0] total_acc;
    range_result_t                    pending_ranges[$];
    int                               failures;
    int                               results_seen;

    function new();
      clear_state();
      failures = 0;
      results_seen = 0;
    endfunction

    function void clear_state();
      prefix_pos = '0;
      field_sel = crhp_pkg::FIELD_START;
      star_seen = 1'b0;
      error_seen = 1'b0;
      start_acc = '0;
      end_acc = '0;
      total_acc = '0;
    endfunction

    // Advances the parse state by one byte; returns 1 unless the byte is ignored.
    function bit parse_byte(input logic [7:0] ch);
      logic [7:0]  lower;
      logic [63:0] digit;
      logic [63:0] acc;
      if (error_seen || star_seen) return 1'b0;
      if (prefix_pos < crhp_pkg::PREFIX_LEN) begin
        lower = (ch >= crhp_pkg::CHAR_UPPER_A && ch <= crhp_pkg::CHAR_UPPER_Z)
              ? ch + crhp_pkg::CASE_OFFSET : ch;
        if (lower == PREFIX_WORD[8*(crhp_pkg::PREFIX_LEN-1-int'(prefix_pos)) +: 8])
          prefix_pos = prefix_pos + 1'b1;
        else
          error_seen = 1'b1;
        return 1'b1;
      end
      if (ch >= crhp_pkg::CHAR_ZERO && ch <= crhp_pkg::CHAR_NINE) begin
        digit = 64'(ch - crhp_pkg::CHAR_ZERO);
        case (field_sel)
          crhp_pkg::FIELD_START: acc = 64'(start_acc);
          crhp_pkg::FIELD_END:   acc = 64'(end_acc);
          default:               acc = 64'(total_acc);
        endcase
        // A digit that would carry past the accumulator width is an error.
        if (acc > (ACC_MASK - digit) / 64'd10) begin
          error_seen = 1'b1;
        end else begin
          acc = acc * 64'd10 + digit;
          case (field_sel)
            crhp_pkg::FIELD_START: start_acc = acc[crhp_pkg::COUNT_WIDTH-1:0];
            crhp_pkg::FIELD_END:   end_acc = acc[crhp_pkg::COUNT_WIDTH-1:0];
            default:               total_acc = acc[crhp_pkg::COUNT_WIDTH-1:0];
          endcase
        end
      end else if (ch == crhp_pkg::CHAR_DASH) begin
        if (field_sel != crhp_pkg::FIELD_START) error_seen = 1'b1;
        else field_sel = crhp_pkg::FIELD_END;
      end else if (ch == crhp_pkg::CHAR_SLASH) begin
        if (field_sel != crhp_pkg::FIELD_END) error_seen = 1'b1;
        else field_sel = crhp_pkg::FIELD_TOTAL;
      end else if (ch == crhp_pkg::CHAR_STAR) begin
        if (field_sel != crhp_pkg::FIELD_TOTAL) error_seen = 1'b1;
        else star_seen = 1'b1;
      end else begin
        error_seen = 1'b1;
      end
      return 1'b1;
    endfunction

    // Notes an accepted request; the last byte of a value yields one range.
    function bit note_byte(input logic [7:0] ch, input bit last);
      bit            took;
      bit            bad;
      range_result_t want;
      took = parse_byte(ch);
      if (last) begin
        bad = error_seen || prefix_pos < crhp_pkg::PREFIX_LEN
           || field_sel != crhp_pkg::FIELD_TOTAL;
        if (!bad) begin
          if (star_seen && total_acc != 0) bad = 1'b1;
          if (!star_seen && total_acc == 0) bad = 1'b1;
          if (start_acc > end_acc) bad = 1'b1;
          if (!star_seen && (start_acc >= total_acc || end_acc >= total_acc)) bad = 1'b1;
        end
        want = '0;
        if (bad) begin
          want.status = 1'b1;
        end else begin
          want.start_offset = start_acc;
          want.end_offset = end_acc;
          want.range_total = star_seen ? '0 : total_acc;
          want.total_wildcard = star_seen;
        end
        pending_ranges.push_back(want);
        clear_state();
      end
      return took;
    endfunction

    function void report(input bit had_want, input range_result_t want,
                         input range_result_t got);
      failures++;
      if (failures <= 10) begin
        if (had_want)
          $display("range mismatch: expected status %0d start %0d end %0d",
                   want.status, want.start_offset, want.end_offset,
                   " total %0d unknown %0d", want.range_total, want.total_wildcard);
        else
          $display("range mismatch: no result was expected");
        $display("  got status %0d start %0d end %0d total %0d unknown %0d",
                 got.status, got.start_offset, got.end_offset, got.range_total,
                 got.total_wildcard);
      end
    endfunction

    // Compares an accepted result with the oldest range still expected.
    function void check_result(input range_result_t got);
      range_result_t want;
      results_seen++;
      if (pending_ranges.size() == 0) begin
        report(1'b0, '0, got);
        return;
      end
      want = pending_ranges.pop_front();
      if (got.status !== want.status || got.start_offset !== want.start_offset ||
          got.end_offset !== want.end_offset || got.range_total !== want.range_total ||
          got.total_wildcard !== want.total_wildcard)
        report(1'b1, want, got);
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   counted_items;
  int   value_count;
  int   guard;
  logic [7:0] header_bytes[$];
  header_value_scoreboard sb;

  crhp_byte_if   byte_chan ();
  crhp_result_if result_chan ();

  content_range_header_parser_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result side: check each accepted result and stall at random.
  always @(posedge clk) begin
    range_result_t got;
    if (rst) begin
      result_chan.ready <= 1'b0;
    end else begin
      if (result_chan.valid && result_chan.ready) begin
        got.status = result_chan.status;
        got.start_offset = result_chan.start_offset;
        got.end_offset = result_chan.end_offset;
        got.range_total = result_chan.range_total;
        got.total_wildcard = result_chan.total_wildcard;
        sb.check_result(got);
      end
      result_chan.ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // Offsets are mostly short, with some near and beyond the accumulator limit.
  function automatic logic [63:0] pick_offset();
    logic [63:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = 64'($urandom_range(999));
      5, 6:          v = 64'($urandom);
      7:             v = {$urandom, $urandom} & ACC_MASK;
      8:             v = ACC_MASK - 64'($urandom_range(20));
      default:       v = $urandom_range(1) ? ACC_MASK + 64'd1 + 64'($urandom_range(20))
                                           : {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) header_bytes.push_back(s[i]);
  endtask

  // The prefix letters come in a random mix of cases.
  task automatic push_prefix();
    logic [7:0] ch;
    for (int i = 0; i < crhp_pkg::PREFIX_LEN; i++) begin
      ch = PREFIX_WORD[8*(crhp_pkg::PREFIX_LEN-1-i) +: 8];
      if (ch != 8'h20 && $urandom_range(1)) ch = ch - crhp_pkg::CASE_OFFSET;
      header_bytes.push_back(ch);
    end
  endtask

  // Decimal digits of a number, sometimes with leading zeros.
  task automatic push_number(input logic [63:0] v);
    logic [7:0] digs[$];
    int zeros;
    zeros = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) header_bytes.push_back(crhp_pkg::CHAR_ZERO);
    do begin
      digs.push_front(crhp_pkg::CHAR_ZERO + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[i]) header_bytes.push_back(digs[i]);
  endtask

  // A complete value; ordered offsets under a fair total mostly parse as valid.
  task automatic build_header(input bit ordered, input bit fair_total, input bit use_star);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    a = pick_offset();
    b = pick_offset();
    if (ordered && a > b) begin
      t = a;
      a = b;
      b = t;
    end
    push_prefix();
    push_number(a);
    header_bytes.push_back(crhp_pkg::CHAR_DASH);
    push_number(b);
    header_bytes.push_back(crhp_pkg::CHAR_SLASH);
    if (use_star) begin
      // Zero digits before the star are allowed, any other digit is not.
      case ($urandom_range(9))
        0:       repeat ($urandom_range(1, 2)) header_bytes.push_back(crhp_pkg::CHAR_ZERO);
        1:       header_bytes.push_back(8'($urandom_range(8'h31, 8'h39)));
        default: ;
      endcase
      header_bytes.push_back(crhp_pkg::CHAR_STAR);
      repeat ($urandom_range(3)) header_bytes.push_back(8'($urandom_range(255)));
    end else begin
      if (fair_total) t = b + 64'd1 + 64'($urandom_range(99));
      else t = ($urandom_range(3) == 0) ? 64'd0 : pick_offset();
      push_number(t);
    end
  endtask

  // Breaks a value by a stray byte, a misplaced separator or a cut.
  task automatic corrupt_header();
    int pos;
    pos = $urandom_range(header_bytes.size() - 1);
    case ($urandom_range(2))
      0: header_bytes[pos] = 8'($urandom_range(255));
      1: case ($urandom_range(2))
           0:       header_bytes[pos] = crhp_pkg::CHAR_DASH;
           1:       header_bytes[pos] = crhp_pkg::CHAR_SLASH;
           default: header_bytes[pos] = crhp_pkg::CHAR_STAR;
         endcase
      default: while (header_bytes.size() > pos + 1) void'(header_bytes.pop_back());
    endcase
  endtask

  // Offers one byte and waits for its request to be taken.
  task automatic send_byte(input logic [7:0] ch, input bit last);
    while (!steady && $urandom_range(99) < 14) begin
      byte_chan.valid <= 1'b0;
      @(posedge clk);
    end
    byte_chan.valid <= 1'b1;
    byte_chan.value_byte <= ch;
    byte_chan.is_last <= last;
    @(posedge clk);
    while (!byte_chan.ready) @(posedge clk);
    void'(sb.note_byte(ch, last));
    counted_items++;
  endtask

  task automatic send_header();
    foreach (header_bytes[i]) send_byte(header_bytes[i], i == header_bytes.size() - 1);
    header_bytes.delete();
  endtask

  initial begin
    int kind;
    rst = 1'b1;
    steady = 1'b0;
    byte_chan.valid = 1'b0;
    byte_chan.value_byte = 8'h00;
    byte_chan.is_last = 1'b0;
    counted_items = 0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: a one-byte value, an upper-case prefix with an unknown total
    // and an ignored last byte, and an end offset equal to the total.
    header_bytes.push_back(8'h00);
    send_header();
    push_text("BYTES 0-0/*");
    header_bytes.push_back(8'hFF);
    send_header();
    push_text("bytes 9-9/9");
    send_header();

    // Random values: mostly well formed, the rest broken or plain noise.
    value_count = 0;
    while (counted_items < ITEM_TARGET) begin
      steady = (value_count >= 20 && value_count < 32);
      if (value_count == 10) begin
        while (sb.pending_ranges.size() != 0) begin
          byte_chan.valid <= 1'b0;
          @(posedge clk);
        end
      end
      kind = $urandom_range(99);
      if (kind < 55) begin
        build_header(1'b1, $urandom_range(3) != 0, $urandom_range(4) == 0);
      end else if (kind < 75) begin
        build_header(1'b0, 1'b0, $urandom_range(5) == 0);
      end else if (kind < 90) begin
        build_header(1'b1, 1'b1, $urandom_range(4) == 0);
        corrupt_header();
      end else begin
        if ($urandom_range(1)) push_prefix();
        repeat ($urandom_range(1, 8)) header_bytes.push_back(8'($urandom_range(255)));
      end
      send_header();
      value_count++;
    end
    byte_chan.valid <= 1'b0;

    // Drain the outstanding ranges, then allow for the check stage.
    guard = 0;
    while (sb.pending_ranges.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    sb.failures += sb.pending_ranges.size();
    if (sb.failures == 0) begin
      $display("content_range_header_parser_unit_test: PASS");
    end else begin
      $display("content_range_header_parser_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #400000;
    $display("content_range_header_parser_unit_test: FAIL");
    $finish;
  end

endmodule : content_range_header_parser_unit_test

`default_nettype wire
